FILE: hdl/assert_macros.svh
// assertion macros used by the checker file of the level meter
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define AMR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define AMR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/amr_pkg.sv
// shared constants, state codes and register indexes of the level meter
// no dependencies; imported by every module of the block
`default_nettype none

package amr_pkg;

   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_MAX_WINDOW   = 8192;
   localparam int DEF_SAMPLE_BITS  = 24;

   localparam int CH_FIELD_W  = 3;
   localparam int WIN_REG_W   = 14;
   localparam int CNT_REG_W   = 4;
   localparam int LEVEL_W     = 24;
   localparam int FRAME_W     = 32;
   localparam int ACC_W       = 64;
   localparam int ROOT_W      = ACC_W / 2;
   localparam int RSP_DATA_W  = 2 * LEVEL_W + FRAME_W;
   localparam int RSP_USER_W  = CH_FIELD_W + 1;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd1;

   localparam logic [CNT_REG_W-1:0] RESET_CHANNEL_COUNT = 4'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS,
      ST_POS_WAIT,
      ST_READ,
      ST_ADD,
      ST_WRITE,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_OVR_MUL,
      ST_OVR_LD,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } amr_state_type;

endpackage

`default_nettype wire

FILE: hdl/amr_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on amr_pkg for the operand width
`default_nettype none

module amr_div import amr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ACC_W-1:0] dividend,
   input  logic [ACC_W-1:0] divisor,
   output logic             done,
   output logic [ACC_W-1:0] quotient,
   output logic [ACC_W-1:0] remainder
);

   localparam int CNT_W = $clog2(ACC_W + 1);

   logic [ACC_W-1:0] quo_ff, quo_in;
   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ACC_W+1:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // partial remainder with the next dividend bit, minus divisor; top bit is the borrow
      diff = {1'b0, rem_ff, quo_ff[ACC_W-1]} - {2'b00, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(ACC_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[ACC_W+1]) begin
            rem_in = {rem_ff[ACC_W-2:0], quo_ff[ACC_W-1]};
         end else begin
            rem_in = diff[ACC_W-1:0];
         end
         quo_in = {quo_ff[ACC_W-2:0], ~diff[ACC_W+1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: hdl/amr_isqrt.sv
// serial floor square root, two radicand bits per cycle
// depends on amr_pkg for the radicand and root widths
`default_nettype none

module amr_isqrt import amr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ACC_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [ACC_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              fits;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[ACC_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      fits    = rem_sh >= trial;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sh - trial : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], fits};
         rad_in  = {rad_ff[ACC_W-3:0], 2'b00};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

FILE: hdl/audio_peak_rms_meter.sv
// Peak and RMS level meter for interleaved audio.
// req channel: one sample item per handshake, channel index in tuser, end of run in tlast.
// rsp channel: on the end-of-run item, one result per active channel (channel 0 first)
//   and then the overall result, which carries tlast.
// csr channel: index 0 window length in frames (0 = whole-run RMS), index 1 channel count;
//   always ready, to be written only while no run result is outstanding.
// Sample items are handled one at a time (accept, memory read, saturating add, write back),
// bounded by the read-modify-write of the per-channel memory and the history memory.
// Each result takes a serial divide and then a serial square root;
// both units are shared by all results.
// After the last result is loaded, and after reset, a clearing pass zeroes every entry
// of both memories; req_tready stays low then.
// A write to the window length triggers a recompute of the history position (by a divide
// when the window is nonzero) before the next sample item is accepted.
// The result register holds while rsp_tready is low; the next result is computed
// meanwhile and waits for the register to free up.
// Depends on amr_pkg, amr_div and amr_isqrt.
`default_nettype none

module audio_peak_rms_meter import amr_pkg::*; #(
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,   // sample
   input  logic [CH_FIELD_W-1:0]               req_tuser,   // channel
   input  logic                                req_tlast,   // end_of_item
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_DATA_W-1:0]               rsp_tdata,   // peak_level, peak_frame, rms_level
   output logic [RSP_USER_W-1:0]               rsp_tuser,   // result_channel, is_overall
   output logic                                rsp_tlast,   // last_result
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [CSR_IDX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]               csr_data
);

   localparam int CH_LIMIT = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
   localparam int CA_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int HA_W     = $clog2(MAX_WINDOW);
   localparam int CLR_LEN  = (MAX_WINDOW > MAX_CHANNELS) ? MAX_WINDOW : MAX_CHANNELS;
   localparam int CLR_W    = $clog2(CLR_LEN);
   localparam int ROW_W    = MAX_CHANNELS * SAMPLE_BITS;
   localparam int SQ_W     = 2 * SAMPLE_BITS;
   localparam int PROD_W   = FRAME_W + CNT_REG_W;

   typedef struct packed {
      logic [ACC_W-1:0]       sum;
      logic [ACC_W-1:0]       max_win;
      logic [SAMPLE_BITS-1:0] peak;
      logic [FRAME_W-1:0]     peak_frame;
   } chan_entry_type;

   // memories
   chan_entry_type         chan_mem [MAX_CHANNELS];
   logic [ROW_W-1:0]       hist_mem [MAX_WINDOW];
   chan_entry_type         chan_rd_ff;
   logic [ROW_W-1:0]       hist_rd_ff;
   logic [CA_W-1:0]        chan_rd_addr, chan_wr_addr;
   logic                   chan_we;
   chan_entry_type         chan_wr_data;
   logic [HA_W-1:0]        hist_wr_addr;
   logic                   hist_we;
   logic [ROW_W-1:0]       hist_wr_data;

   // configuration
   logic [WIN_REG_W-1:0]   win_len_ff, win_len_in;
   logic [CNT_REG_W-1:0]   chan_cnt_ff, chan_cnt_in;
   logic [CNT_REG_W-1:0]   n_eff;
   logic [WIN_REG_W-1:0]   win_eff;
   logic                   win_on;
   logic                   csr_win_wr;

   // control and datapath registers
   amr_state_type          state_ff, state_in;
   logic [CLR_W-1:0]       clr_ff, clr_in;
   logic [HA_W-1:0]        pos_ff, pos_in;
   logic                   pos_stale_ff, pos_stale_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic [SAMPLE_BITS-1:0] opeak_ff, opeak_in;
   logic [FRAME_W-1:0]     opframe_ff, opframe_in;
   logic [ACC_W-1:0]       owin_ff, owin_in;
   logic [SAMPLE_BITS-1:0] smp_mag_ff, smp_mag_in;
   logic [CA_W-1:0]        smp_ch_ff, smp_ch_in;
   logic                   smp_ok_ff, smp_ok_in;
   logic                   smp_last_ff, smp_last_in;
   chan_entry_type         ent_ff, ent_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [SQ_W-1:0]        osq_ff, osq_in;
   logic [ACC_W-1:0]       sum1_ff, sum1_in;
   logic [CNT_REG_W-1:0]   emit_k_ff, emit_k_in;
   logic                   emit_ovr_ff, emit_ovr_in;
   logic [ACC_W-1:0]       total_ff, total_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] res_peak_ff, res_peak_in;
   logic [FRAME_W-1:0]     res_pframe_ff, res_pframe_in;
   logic                   zero_div_ff, zero_div_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]  rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;

   // shared arithmetic units
   logic                   div_start, div_done;
   logic [ACC_W-1:0]       div_dividend, div_divisor, div_quo, div_rem;
   logic                   sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]      sqrt_root;

   // combinational helpers
   logic                   accept;
   logic                   out_free;
   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] old_mag;
   logic [ACC_W:0]         add_wide;
   logic [ACC_W:0]         sub_wide;
   logic [ACC_W-1:0]       sum2;
   logic [ACC_W:0]         tot_wide;
   logic [HA_W:0]          pos_next;
   logic                   frame_end;
   logic [CNT_REG_W-1:0]   emit_k_next;
   logic [LEVEL_W-1:0]     rms_val;

   amr_div u_amr_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   amr_isqrt u_amr_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quo),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // effective configuration
   always_comb begin
      if (chan_cnt_ff == '0) begin
         n_eff = CNT_REG_W'(1);
      end else if (32'(chan_cnt_ff) > CH_LIMIT) begin
         n_eff = CNT_REG_W'(CH_LIMIT);
      end else begin
         n_eff = chan_cnt_ff;
      end
      if (32'(win_len_ff) > MAX_WINDOW) begin
         win_eff = WIN_REG_W'(MAX_WINDOW);
      end else begin
         win_eff = win_len_ff;
      end
      win_on = win_eff != '0;
   end

   assign csr_ready  = 1'b1;
   assign csr_win_wr = csr_valid && (csr_index == CSR_WINDOW_LENGTH);

   always_comb begin
      win_len_in  = win_len_ff;
      chan_cnt_in = chan_cnt_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: win_len_in  = csr_data;
            CSR_CHANNEL_COUNT: chan_cnt_in = csr_data[CNT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (32'(clr_ff) == CLR_LEN - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pos_stale_ff) state_in = ST_POS;
            else if (req_tvalid) state_in = ST_READ;
         end
         ST_POS: begin
            state_in = win_on ? ST_POS_WAIT : ST_IDLE;
         end
         ST_POS_WAIT: begin
            if (div_done) state_in = ST_IDLE;
         end
         ST_READ: begin
            if (smp_ok_ff) state_in = ST_ADD;
            else state_in = smp_last_ff ? ST_EMIT_RD : ST_IDLE;
         end
         ST_ADD: state_in = ST_WRITE;
         ST_WRITE: state_in = smp_last_ff ? ST_EMIT_RD : ST_IDLE;
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: state_in = ST_DIV;
         ST_OVR_MUL: state_in = ST_OVR_LD;
         ST_OVR_LD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               if (emit_ovr_ff) state_in = ST_CLEAR;
               else if (emit_k_next < n_eff) state_in = ST_EMIT_RD;
               else state_in = ST_OVR_MUL;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // handshake and unit controls
   always_comb begin
      req_tready   = (state_ff == ST_IDLE) && !pos_stale_ff;
      div_start    = 1'b0;
      sqrt_start   = (state_ff == ST_DIV) && div_done;
      div_dividend = win_on ? chan_rd_ff.max_win : chan_rd_ff.sum;
      div_divisor  = win_on ? ACC_W'(win_eff) : ACC_W'(frame_ff);
      case (state_ff)
         ST_POS: begin
            div_start    = win_on;
            div_dividend = ACC_W'(frame_ff);
            div_divisor  = ACC_W'(win_eff);
         end
         ST_EMIT_LD: div_start = 1'b1;
         ST_OVR_LD: begin
            div_start    = 1'b1;
            div_dividend = win_on ? owin_ff : total_ff;
            div_divisor  = win_on ? ACC_W'(win_eff) : ACC_W'(prod_ff);
         end
         default: ;
      endcase
   end

   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign raw         = req_tdata[SAMPLE_BITS-1:0];
   assign old_mag     = hist_rd_ff[smp_ch_ff*SAMPLE_BITS +: SAMPLE_BITS];
   assign add_wide    = {1'b0, ent_ff.sum} + {1'b0, ACC_W'(sq_ff)};
   assign sub_wide    = {1'b0, sum1_ff} - {1'b0, ACC_W'(osq_ff)};
   assign tot_wide    = {1'b0, total_ff} + {1'b0, chan_rd_ff.sum};
   assign pos_next    = {1'b0, pos_ff} + (HA_W+1)'(1);
   assign frame_end   = 32'(smp_ch_ff) == 32'(n_eff) - 1;
   assign emit_k_next = emit_k_ff + CNT_REG_W'(1);
   assign rms_val     = zero_div_ff ? '0 : LEVEL_W'(sqrt_root);

   // sliding sum floored at zero once the oldest square leaves the window
   always_comb begin
      if (!win_on) sum2 = sum1_ff;
      else if (sub_wide[ACC_W]) sum2 = '0;
      else sum2 = sub_wide[ACC_W-1:0];
   end

   // datapath and memory controls
   always_comb begin
      clr_in        = clr_ff;
      pos_in        = pos_ff;
      pos_stale_in  = pos_stale_ff;
      frame_in      = frame_ff;
      opeak_in      = opeak_ff;
      opframe_in    = opframe_ff;
      owin_in       = owin_ff;
      smp_mag_in    = smp_mag_ff;
      smp_ch_in     = smp_ch_ff;
      smp_ok_in     = smp_ok_ff;
      smp_last_in   = smp_last_ff;
      ent_in        = ent_ff;
      row_in        = row_ff;
      sq_in         = sq_ff;
      osq_in        = osq_ff;
      sum1_in       = sum1_ff;
      emit_k_in     = emit_k_ff;
      emit_ovr_in   = emit_ovr_ff;
      total_in      = total_ff;
      prod_in       = prod_ff;
      res_peak_in   = res_peak_ff;
      res_pframe_in = res_pframe_ff;
      zero_div_in   = zero_div_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      chan_rd_addr  = CA_W'(req_tuser);
      chan_we       = 1'b0;
      chan_wr_addr  = smp_ch_ff;
      chan_wr_data  = ent_ff;
      hist_we       = 1'b0;
      hist_wr_addr  = pos_ff;
      hist_wr_data  = row_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in       = clr_ff + CLR_W'(1);
            chan_wr_addr = CA_W'(clr_ff);
            chan_wr_data = '0;
            chan_we      = 32'(clr_ff) < MAX_CHANNELS;
            hist_wr_addr = HA_W'(clr_ff);
            hist_wr_data = '0;
            hist_we      = 32'(clr_ff) < MAX_WINDOW;
            if (32'(clr_ff) == CLR_LEN - 1) begin
               clr_in     = '0;
               frame_in   = '0;
               pos_in     = '0;
               opeak_in   = '0;
               opframe_in = '0;
               owin_in    = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               smp_mag_in  = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
               smp_ch_in   = CA_W'(req_tuser);
               smp_ok_in   = {1'b0, req_tuser} < n_eff;
               smp_last_in = req_tlast;
               emit_k_in   = '0;
               emit_ovr_in = 1'b0;
               total_in    = '0;
            end
         end
         ST_POS: begin
            if (!win_on) pos_stale_in = 1'b0;
         end
         ST_POS_WAIT: begin
            if (div_done) begin
               pos_in       = div_rem[HA_W-1:0];
               pos_stale_in = 1'b0;
            end
         end
         ST_READ: begin
            ent_in = chan_rd_ff;
            row_in = hist_rd_ff;
            sq_in  = SQ_W'(smp_mag_ff) * SQ_W'(smp_mag_ff);
            osq_in = SQ_W'(old_mag) * SQ_W'(old_mag);
         end
         ST_ADD: begin
            sum1_in = add_wide[ACC_W] ? '1 : add_wide[ACC_W-1:0];
         end
         ST_WRITE: begin
            chan_we      = 1'b1;
            chan_wr_data = ent_ff;
            chan_wr_data.sum = sum2;
            if (win_on && (sum2 > ent_ff.max_win)) chan_wr_data.max_win = sum2;
            if (smp_mag_ff > ent_ff.peak) begin
               chan_wr_data.peak       = smp_mag_ff;
               chan_wr_data.peak_frame = frame_ff;
            end
            if (smp_mag_ff > opeak_ff) begin
               opeak_in   = smp_mag_ff;
               opframe_in = frame_ff;
            end
            if (win_on && (sum2 > owin_ff)) owin_in = sum2;
            hist_we = win_on;
            hist_wr_data[smp_ch_ff*SAMPLE_BITS +: SAMPLE_BITS] = smp_mag_ff;
            if (frame_end) begin
               frame_in = frame_ff + FRAME_W'(1);
               if (win_on) begin
                  if (32'(pos_next) >= 32'(win_eff)) pos_in = '0;
                  else pos_in = pos_next[HA_W-1:0];
               end
            end
         end
         ST_EMIT_RD: begin
            chan_rd_addr = CA_W'(emit_k_ff);
         end
         ST_EMIT_LD: begin
            total_in      = tot_wide[ACC_W] ? '1 : tot_wide[ACC_W-1:0];
            res_peak_in   = chan_rd_ff.peak;
            res_pframe_in = chan_rd_ff.peak_frame;
            zero_div_in   = !win_on && (frame_ff == '0);
         end
         ST_OVR_MUL: begin
            prod_in = PROD_W'(frame_ff) * PROD_W'(n_eff);
         end
         ST_OVR_LD: begin
            res_peak_in   = opeak_ff;
            res_pframe_in = opframe_ff;
            zero_div_in   = !win_on && (prod_ff == '0);
            emit_ovr_in   = 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {rms_val, res_pframe_ff, LEVEL_W'(res_peak_ff)};
               rsp_user_in  = {emit_ovr_ff,
                               emit_ovr_ff ? CH_FIELD_W'(0) : emit_k_ff[CH_FIELD_W-1:0]};
               rsp_last_in  = emit_ovr_ff;
               emit_k_in    = emit_k_next;
            end
         end
         default: ;
      endcase

      // a new window length invalidates the history position
      if (csr_win_wr) pos_stale_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (chan_we) chan_mem[chan_wr_addr] <= chan_wr_data;
      chan_rd_ff <= chan_mem[chan_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_wr_addr] <= hist_wr_data;
      hist_rd_ff <= hist_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pos_stale_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_len_ff   <= '0;
         chan_cnt_ff  <= RESET_CHANNEL_COUNT;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pos_stale_ff <= pos_stale_in;
         rsp_valid_ff <= rsp_valid_in;
         win_len_ff   <= win_len_in;
         chan_cnt_ff  <= chan_cnt_in;
      end
      pos_ff        <= pos_in;
      frame_ff      <= frame_in;
      opeak_ff      <= opeak_in;
      opframe_ff    <= opframe_in;
      owin_ff       <= owin_in;
      smp_mag_ff    <= smp_mag_in;
      smp_ch_ff     <= smp_ch_in;
      smp_ok_ff     <= smp_ok_in;
      smp_last_ff   <= smp_last_in;
      ent_ff        <= ent_in;
      row_ff        <= row_in;
      sq_ff         <= sq_in;
      osq_ff        <= osq_in;
      sum1_ff       <= sum1_in;
      emit_k_ff     <= emit_k_in;
      emit_ovr_ff   <= emit_ovr_in;
      total_ff      <= total_in;
      prod_ff       <= prod_in;
      res_peak_ff   <= res_peak_in;
      res_pframe_ff <= res_pframe_in;
      zero_div_ff   <= zero_div_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/amr_checker.sv
// port-level checks of the level meter, bound to the top level
// depends on amr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module amr_checker import amr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // stalled result keeps its payload
   `AMR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")

   // only the overall result closes a run
   `AMR_ASSERT_SAME(a_last_is_overall, clock, reset, rsp_tvalid, rsp_tlast == rsp_tuser[CH_FIELD_W], "tlast and overall flag disagree")

   // overall result reports channel zero
   `AMR_ASSERT_SAME(a_overall_ch0, clock, reset, rsp_tvalid && rsp_tuser[CH_FIELD_W], rsp_tuser[CH_FIELD_W-1:0] == '0, "overall result with nonzero channel")

   // no sample item taken while a run's results are still being produced
   `AMR_ASSERT_SAME(a_no_req_mid_run, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready, "sample accepted during result output")

   // end of run stops intake in the following cycle
   `AMR_ASSERT_NEXT(a_stop_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "ready after end of run")

endmodule

bind audio_peak_rms_meter amr_checker u_amr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

FILE: verif/tb_audio_peak_rms_meter.sv
// self-checking testbench for the audio peak and rms level meter
// drives sample runs under several channel and window settings, checks every result
// against an in-bench level predictor; depends on amr_pkg and audio_peak_rms_meter
`timescale 1ns / 100ps

module tb_audio_peak_rms_meter;
   import amr_pkg::*;

   localparam int NCH     = DEF_MAX_CHANNELS;
   localparam int NWIN    = DEF_MAX_WINDOW;
   localparam int IDLE_LIMIT = 40000;
   localparam int LONG_HOLD  = 3000;

   typedef struct packed {
      logic [2:0]  chan;
      logic        overall;
      logic [23:0] peak;
      logic [31:0] frame;
      logic [23:0] rms;
      logic        last;
   } level_result_type;

   typedef struct {
      logic [23:0] smp;
      logic [2:0]  chan;
      logic        eoi;
      bit          typed;
      logic [23:0] t_peak;
      logic [31:0] t_frame;
      logic [23:0] t_rms;
   } run_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic [CH_FIELD_W-1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WINDOW_LENGTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   audio_peak_rms_meter u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [13:0] cfg_window;
   logic [3:0]  cfg_channels;
   logic [63:0] sumsq [NCH];
   logic [63:0] max_energy [NCH];
   logic [23:0] ch_peak [NCH];
   logic [31:0] ch_peak_frame [NCH];
   logic [23:0] all_peak;
   logic [31:0] all_peak_frame;
   logic [63:0] all_max_energy;
   logic [31:0] frame_cnt;
   logic [23:0] history [NCH][NWIN];

   level_result_type expected_levels[$];
   int errors = 0;
   int hold_req = 0;
   int burst_left = 0;

   function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic int active_channels();
      if (cfg_channels == 0) return 1;
      if (int'(cfg_channels) > NCH) return NCH;
      return int'(cfg_channels);
   endfunction

   function automatic int active_window();
      return (int'(cfg_window) > NWIN) ? NWIN : int'(cfg_window);
   endfunction

   task automatic clear_levels();
      for (int c = 0; c < NCH; c++) begin
         sumsq[c] = 0;
         max_energy[c] = 0;
         ch_peak[c] = 0;
         ch_peak_frame[c] = 0;
         for (int p = 0; p < NWIN; p++) history[c][p] = 0;
      end
      all_peak = 0;
      all_peak_frame = 0;
      all_max_energy = 0;
      frame_cnt = 0;
   endtask

   task automatic predict_levels(logic [23:0] smp, logic [2:0] chan, logic eoi);
      int n;
      int win;
      int pos;
      logic [63:0] mag;
      logic [63:0] old_sq;
      logic [63:0] total;
      logic [63:0] rms;
      logic [63:0] div;
      level_result_type r;
      n = active_channels();
      win = active_window();
      mag = smp[23] ? (64'h100_0000 - {40'd0, smp}) : {40'd0, smp};
      if (chan < n) begin
         sumsq[chan] = sat_sum(sumsq[chan], mag * mag);
         if (mag > all_peak) begin
            all_peak = mag[23:0];
            all_peak_frame = frame_cnt;
         end
         if (mag > ch_peak[chan]) begin
            ch_peak[chan] = mag[23:0];
            ch_peak_frame[chan] = frame_cnt;
         end
         if (win != 0) begin
            pos = frame_cnt % win;
            old_sq = {40'd0, history[chan][pos]} * {40'd0, history[chan][pos]};
            history[chan][pos] = mag[23:0];
            sumsq[chan] = (sumsq[chan] >= old_sq) ? sumsq[chan] - old_sq : 0;
            if (sumsq[chan] > all_max_energy) all_max_energy = sumsq[chan];
            if (sumsq[chan] > max_energy[chan]) max_energy[chan] = sumsq[chan];
         end
         if (chan == n - 1) frame_cnt++;
      end
      if (!eoi) return;
      total = 0;
      for (int k = 0; k < n; k++) begin
         if (win != 0) rms = floor_root(max_energy[k] / win);
         else rms = frame_cnt ? floor_root(sumsq[k] / frame_cnt) : 0;
         total = sat_sum(total, sumsq[k]);
         r.chan = k[2:0];
         r.overall = 1'b0;
         r.peak = ch_peak[k];
         r.frame = ch_peak_frame[k];
         r.rms = rms[23:0];
         r.last = 1'b0;
         expected_levels.push_back(r);
      end
      if (win != 0) begin
         rms = floor_root(all_max_energy / win);
      end else begin
         div = 64'(frame_cnt) * n;
         rms = div ? floor_root(total / div) : 0;
      end
      r.chan = 0;
      r.overall = 1'b1;
      r.peak = all_peak;
      r.frame = all_peak_frame;
      r.rms = rms[23:0];
      r.last = 1'b1;
      expected_levels.push_back(r);
      clear_levels();
   endtask

   // one sample item, with bursts and gaps between items
   task automatic send_sample(run_row_type row);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= row.smp;
      req_tuser <= row.chan;
      req_tlast <= row.eoi;
      do @(posedge clock); while (!req_tready);
      predict_levels(row.smp, row.chan, row.eoi);
      if (row.typed) begin
         expected_levels[$].peak = row.t_peak;
         expected_levels[$].frame = row.t_frame;
         expected_levels[$].rms = row.t_rms;
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after its last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WINDOW_LENGTH) cfg_window = val;
      else if (idx == CSR_CHANNEL_COUNT) cfg_channels = val[3:0];
   endtask

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'(int'($urandom_range(0, 64)) - 32);
         default: return 24'($urandom);
      endcase
   endfunction

   // interleaved run with some items moved to a random channel, stray or active
   task automatic random_run(int frames);
      run_row_type row;
      int n;
      int total;
      n = active_channels();
      total = frames * n;
      for (int i = 0; i < total; i++) begin
         row.smp = pick_sample();
         row.chan = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'(i % n);
         row.eoi = (i == total - 1);
         row.typed = 0;
         send_sample(row);
      end
   endtask

   // receiver: changing stall pattern, plus a long hold-off on request
   int rx_mode = 0;
   int rx_left = 0;
   int hold_seen = 0;
   int hold_cnt = 0;
   level_result_type got;
   level_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.chan = rsp_tuser[2:0];
         got.overall = rsp_tuser[3];
         got.peak = rsp_tdata[23:0];
         got.frame = rsp_tdata[55:24];
         got.rms = rsp_tdata[79:56];
         got.last = rsp_tlast;
         if (expected_levels.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, got);
            errors++;
         end else begin
            want = expected_levels.pop_front();
            if (got !== want) begin
               $display("%0t: result mismatch expected %p actual %p", $realtime, want, got);
               errors++;
            end
         end
      end
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_cnt = LONG_HOLD;
      end
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_left = $urandom_range(10, 80);
      end
      rx_left--;
      if (hold_cnt != 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog on cycles with no handshake at all
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else if (++quiet >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   run_row_type dir_rows[] = '{
      // full-scale negative alone: no whole frame, so rms is zero
      '{24'h800000, 3'd0, 1'b1, 1, 24'h800000, 32'd0, 24'd0},
      '{24'h7FFFFF, 3'd0, 1'b0, 0, 0, 0, 0},
      '{24'h7FFFFF, 3'd1, 1'b0, 0, 0, 0, 0},
      '{24'hFFFFFF, 3'd0, 1'b0, 0, 0, 0, 0},
      '{24'h000000, 3'd1, 1'b1, 0, 0, 0, 0},
      // stray channel is ignored but still closes the run
      '{24'h000064, 3'd5, 1'b1, 1, 24'd0, 32'd0, 24'd0},
      // equal magnitudes: the earliest sample keeps the overall peak
      '{24'd1000, 3'd0, 1'b0, 0, 0, 0, 0},
      '{-24'sd1000, 3'd1, 1'b0, 0, 0, 0, 0},
      '{24'd1000, 3'd0, 1'b0, 0, 0, 0, 0},
      '{24'd7, 3'd7, 1'b0, 0, 0, 0, 0},
      '{24'd1000, 3'd1, 1'b1, 0, 0, 0, 0}
   };

   int phase_win[] = '{3, 0, 1, 8192, 16383, 0, 5, 2};
   int phase_ch[]  = '{2, 8, 1, 3, 15, 0, 4, 7};

   initial begin
      cfg_window = 0;
      cfg_channels = RESET_CHANNEL_COUNT;
      clear_levels();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_sample(dir_rows[i]);
      drain_results();

      for (int ph = 0; ph < phase_win.size(); ph++) begin
         write_reg(CSR_WINDOW_LENGTH, CSR_DATA_W'(phase_win[ph]));
         write_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(phase_ch[ph]));
         csr_valid <= 1'b0;
         for (int r = 0; r < 2; r++) begin
            if (ph == 1 && r == 1) hold_req++;
            random_run($urandom_range(1, 6 - (active_channels() > 4 ? 3 : 0)));
         end
         drain_results();
      end

      while (expected_levels.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_levels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
